// File: hdl/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Types and constants for the separator-aware argument tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package sat_pkg;

  typedef enum logic [2:0] {
    MODE_WS     = 3'd0,
    MODE_TOKEN  = 3'd1,
    MODE_STRING = 3'd2,
    MODE_SEP    = 3'd3,
    MODE_ESC    = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_HERE  = 2'd1,
    EV_NEXT  = 2'd2,
    EV_EMPTY = 2'd3
  } arg_event_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] SEP_RESET = 8'h2C;

  typedef struct packed {
    logic [5:0] arg_count;
    logic       end_of_string;
    logic       arg_overflow;
    logic [4:0] arg_index;
    arg_event_t arg_event;
    logic [7:0] out_byte;
    logic [7:0] position;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/separator_aware_argument_tokenizer.sv
// ----------------------------------------------------------------------------
// separator_aware_argument_tokenizer
// Splits a character stream into arguments, rewriting terminators to zero.
// ----------------------------------------------------------------------------
// One input beat per character, one result beat per character. A character's
// result leaves when the following character arrives (the separator check
// needs one character of look-ahead); the final character (tlast) releases
// any held character and itself, yielding two results when one is held. The
// input side takes a beat every cycle while the four-entry result queue has
// room for two more results, which holds whenever results are taken as fast
// as characters arrive: the sustained rate is one character per cycle, and
// each result is registered into the result queue before it leaves.
`default_nettype none

module separator_aware_argument_tokenizer #(
  parameter int MAX_ARGS = 32,
  parameter int MAX_LEN  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // char_byte
  input  wire logic        s_axis_tlast,   // last_char
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // position, out_byte, arg_event,
                                           // arg_index, arg_overflow, arg_count
  output logic             m_axis_tlast    // end_of_string
);
  import sat_pkg::*;

  localparam int POS_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_ARGS + 1);
  localparam int QDEPTH = 4;

  typedef struct packed {
    mode_t             mode;
    mode_t             saved;
    logic              skip;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  cnt;
  } st_t;

  localparam st_t ST_CLEAR = '{mode: MODE_WS, saved: MODE_WS, skip: 1'b0,
                               pos: '0, cnt: '0};

  function automatic void classify(input st_t si, input logic [7:0] bi,
                                   input logic has_next, input logic [7:0] nxt,
                                   input logic eos, input logic [7:0] sep,
                                   output st_t so, output res_t r);
    st_t              s;
    logic [7:0]       b;
    arg_event_t       ev;
    arg_event_t       kind;
    logic             rec;
    logic             ovf;
    logic [4:0]       idx;
    logic [CNT_W+4:0] idx_x;
    logic [CNT_W+5:0] cnt_x;
    logic [POS_W+7:0] pos_x;
    s     = si;
    b     = bi;
    ev    = EV_NONE;
    kind  = EV_NONE;
    rec   = 1'b0;
    ovf   = 1'b0;
    idx   = '0;
    idx_x = '0;
    if (s.skip) begin
      s.skip = 1'b0;
    end else if (s.mode == MODE_ESC) begin
      s.mode = s.saved;
    end else if (s.mode == MODE_STRING) begin
      if (b == CH_QUOTE) begin
        b      = '0;
        s.mode = MODE_WS;
      end
    end else if (b == CH_SPACE || b == CH_TAB) begin
      b      = '0;
      s.mode = MODE_WS;
    end else if (b == CH_QUOTE) begin
      b      = '0;
      s.mode = MODE_STRING;
      rec    = 1'b1;
      kind   = EV_NEXT;
      s.skip = 1'b1;
    end else if (b == CH_BSLASH) begin
      s.saved = s.mode;
      s.mode  = MODE_ESC;
    end else if (b == sep) begin
      b      = '0;
      s.mode = MODE_SEP;
      rec    = 1'b1;
      if (has_next && nxt == sep) begin
        kind = EV_EMPTY;
      end else begin
        kind   = EV_NEXT;
        s.skip = 1'b1;
      end
    end else begin
      if (s.mode == MODE_WS) begin
        rec  = 1'b1;
        kind = EV_HERE;
      end
      s.mode = MODE_TOKEN;
    end
    if (rec) begin
      if (s.cnt < CNT_W'(MAX_ARGS)) begin
        ev    = kind;
        idx_x = {5'b0, s.cnt};
        idx   = idx_x[4:0];
        s.cnt = s.cnt + 1'b1;
      end else begin
        ovf = 1'b1;
      end
    end
    pos_x = {8'b0, s.pos};
    cnt_x = {6'b0, s.cnt};
    r.position      = pos_x[7:0];
    r.out_byte      = b;
    r.arg_event     = ev;
    r.arg_index     = idx;
    r.arg_overflow  = ovf;
    r.end_of_string = eos;
    r.arg_count     = cnt_x[5:0];
    s.pos = (s.pos == POS_W'(MAX_LEN - 1)) ? '0 : s.pos + 1'b1;
    so = s;
  endfunction

  logic [7:0] separator_char;
  st_t        st;
  st_t        st_next;
  logic       held_valid;
  logic       held_byte_unused;
  logic [7:0] held_byte;

  res_t       q [QDEPTH];
  res_t       q_next [QDEPTH];
  logic [2:0] qcnt;
  logic [2:0] qcnt_next;

  st_t        st_a;
  st_t        st_b;
  res_t       res_a;
  res_t       res_b;
  res_t       push0_res;
  logic       s_accept;
  logic       m_accept;
  logic [1:0] npush;
  logic [2:0] base;

  assign held_byte_unused = 1'b0;
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_accept = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (qcnt <= 3'd2);
  assign m_axis_tvalid = (qcnt != 3'd0);
  assign m_axis_tdata  = {2'b00, q[0].arg_count, q[0].arg_overflow, q[0].arg_index,
                          q[0].arg_event, q[0].out_byte, q[0].position};
  assign m_axis_tlast  = q[0].end_of_string;

  always_comb begin
    st_a  = st;
    res_a = '0;
    st_b  = st;
    res_b = '0;
    if (held_valid) begin
      classify(st, held_byte, 1'b1, s_axis_tdata, 1'b0, separator_char, st_a, res_a);
    end
    classify(st_a, s_axis_tdata, 1'b0, 8'h00, 1'b1, separator_char, st_b, res_b);
    st_next = st;
    if (s_accept) begin
      st_next = s_axis_tlast ? ST_CLEAR : st_a;
    end
    push0_res = held_valid ? res_a : res_b;
    npush = 2'd0;
    if (s_accept) begin
      npush = 2'(held_valid) + 2'(s_axis_tlast);
    end
    base = qcnt - 3'(m_accept);
    for (int i = 0; i < QDEPTH; i++) begin
      if (m_accept && i < QDEPTH - 1) begin
        q_next[i] = q[(i + 1) % QDEPTH];
      end else begin
        q_next[i] = q[i];
      end
      if (npush != 2'd0 && 3'(i) == base) begin
        q_next[i] = push0_res;
      end
      if (npush == 2'd2 && 3'(i) == base + 3'd1) begin
        q_next[i] = res_b;
      end
    end
    qcnt_next = base + 3'(npush);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_char <= SEP_RESET;
      st             <= ST_CLEAR;
      held_valid     <= 1'b0;
      qcnt           <= 3'd0;
    end else begin
      if (cfg_wr_en) begin
        separator_char <= cfg_wr_data;
      end
      st   <= st_next;
      qcnt <= qcnt_next;
      if (s_accept) begin
        held_valid <= !s_axis_tlast;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && !s_axis_tlast) begin
      held_byte <= s_axis_tdata | {7'b0, held_byte_unused};
    end
    for (int i = 0; i < QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  a_qcnt_bound: assert property (@(posedge clk) disable iff (rst)
    qcnt <= 3'(QDEPTH))
    else $error("result queue overfilled");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    s_accept && s_axis_tlast |=> !held_valid && st.cnt == '0 && st.pos == '0)
    else $error("string state not cleared after last character");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    st.cnt <= CNT_W'(MAX_ARGS))
    else $error("argument count beyond table size");

  a_two_results: assert property (@(posedge clk) disable iff (rst)
    s_accept && s_axis_tlast && held_valid && !m_accept |=> qcnt == $past(qcnt) + 3'd2)
    else $error("last beat with held character did not queue two results");

endmodule

`default_nettype wire

// File: tb/separator_aware_argument_tokenizer_test.sv
// ----------------------------------------------------------------------------
// separator_aware_argument_tokenizer_test
// Streams strings into the tokenizer and checks every result beat against a
// built-in tokenizer model: rewritten bytes, argument events, indexes,
// overflow, counts and string ends. Runs several separator settings, random
// idle and stall patterns, a long receiver hold-off and full drains.
// ----------------------------------------------------------------------------
module separator_aware_argument_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sat_pkg::*;

  localparam int MAX_ARGS   = 32;
  localparam int MAX_LEN    = 256;
  localparam int QUIET_MAX  = 3000;
  localparam int PHASE_CHARS = 105;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // char_byte
  logic        s_axis_tlast = 1'b0; // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // position, out_byte, arg_event, arg_index,
                                    // arg_overflow, arg_count
  logic        m_axis_tlast;        // end_of_string

  logic [7:0] sep_now = SEP_RESET;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_left = 0;
  int quiet_cycles = 0;
  int chars_sent = 0;

  class tokenizer_scoreboard;
    logic [7:0] sep;
    mode_t mode, saved;
    bit skip, held_v;
    logic [7:0] held_b;
    int pos, nargs;
    int errors;
    res_t expected_tokens[$];

    function new();
      sep = SEP_RESET;
      errors = 0;
      clear_string();
    endfunction

    function void clear_string();
      mode = MODE_WS;
      saved = MODE_WS;
      skip = 0;
      held_v = 0;
      held_b = '0;
      pos = 0;
      nargs = 0;
    endfunction

    function void record_arg(arg_event_t kind, ref res_t r);
      if (nargs < MAX_ARGS) begin
        r.arg_event = kind;
        r.arg_index = nargs[4:0];
        nargs++;
      end else begin
        r.arg_overflow = 1'b1;
      end
    endfunction

    function res_t tokenize_char(logic [7:0] b, bit has_nxt, logic [7:0] nxt, bit eos);
      res_t r;
      r = '0;
      if (skip) begin
        skip = 0;
      end else if (mode == MODE_ESC) begin
        mode = saved;
      end else if (mode == MODE_STRING) begin
        if (b == CH_QUOTE) begin
          b = '0;
          mode = MODE_WS;
        end
      end else if (b == CH_SPACE || b == CH_TAB) begin
        b = '0;
        mode = MODE_WS;
      end else if (b == CH_QUOTE) begin
        b = '0;
        mode = MODE_STRING;
        record_arg(EV_NEXT, r);
        skip = 1;
      end else if (b == CH_BSLASH) begin
        saved = mode;
        mode = MODE_ESC;
      end else if (b == sep) begin
        b = '0;
        mode = MODE_SEP;
        if (has_nxt && nxt == sep) begin
          record_arg(EV_EMPTY, r);
        end else begin
          record_arg(EV_NEXT, r);
          skip = 1;
        end
      end else begin
        if (mode == MODE_WS) record_arg(EV_HERE, r);
        mode = MODE_TOKEN;
      end
      r.position = pos[7:0];
      r.out_byte = b;
      r.end_of_string = eos;
      r.arg_count = nargs[5:0];
      pos = (pos + 1) % MAX_LEN;
      return r;
    endfunction

    function void note_char(logic [7:0] b, logic last);
      if (held_v) begin
        expected_tokens.push_back(tokenize_char(held_b, 1, b, 0));
        held_v = 0;
      end
      if (last) begin
        expected_tokens.push_back(tokenize_char(b, 0, '0, 1));
        clear_string();
      end else begin
        held_b = b;
        held_v = 1;
      end
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t mismatch %s expected %0h got %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_token_beat(logic [31:0] data, logic last);
      res_t e;
      if (expected_tokens.size() == 0) begin
        errors++;
        $display("%0t unexpected beat expected none got %h last %b", $time, data, last);
        return;
      end
      e = expected_tokens.pop_front();
      compare_field("position", e.position, data[7:0]);
      compare_field("out_byte", e.out_byte, data[15:8]);
      compare_field("arg_event", e.arg_event, data[17:16]);
      compare_field("arg_index", e.arg_index, data[22:18]);
      compare_field("arg_overflow", e.arg_overflow, data[23]);
      compare_field("arg_count", e.arg_count, data[29:24]);
      compare_field("end_of_string", e.end_of_string, last);
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction
  endclass

  tokenizer_scoreboard sb = new();

  separator_aware_argument_tokenizer #(
    .MAX_ARGS(MAX_ARGS),
    .MAX_LEN (MAX_LEN)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: check accepted beats, then pick next ready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_token_beat(m_axis_tdata, m_axis_tlast);
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_MAX);
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_char(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_char(b, last);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(11))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_QUOTE;
      3: return CH_BSLASH;
      4, 5: return sep_now;
      6, 7: return 8'($urandom_range(255));
      default: return 8'h61 + 8'($urandom_range(25));
    endcase
  endfunction

  task automatic send_random_string(input int len);
    for (int i = 0; i < len; i++) send_char(pick_char(), i == len - 1);
  endtask

  // wait for every expected beat, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_separator(input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sep_now = v;
    sb.sep = v;
  endtask

  initial begin
    logic [7:0] seps[8];
    int target;
    int len;
    seps = '{SEP_RESET, 8'h00, 8'hFF, CH_SPACE, CH_QUOTE, CH_BSLASH, CH_TAB,
             8'($urandom_range(255))};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed strings with the reset separator
    send_text("a b");
    send_text("\"x y\"");
    send_text("a\\,b");
    send_text("a,,b");
    send_text("ab,");
    send_text("\"");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        drain();
        write_separator(seps[p]);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (p == 0) holdoff_left = 300;
      // long string: position wrap and argument table overflow
      if (p % 3 == 0) send_random_string($urandom_range(300, 260));
      target = chars_sent + PHASE_CHARS;
      while (chars_sent < target) begin
        len = $urandom_range(16, 1);
        if (len > target - chars_sent) len = target - chars_sent;
        send_random_string(len);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
